// ----- hdl/rpop_pkg.sv -----
`default_nettype none

package rpop_pkg;

    localparam int unsigned DIST_BITS = 32;
    localparam int unsigned DIV_BITS  = DIST_BITS + 1;
    localparam int unsigned MAX_PTS   = 6;
    localparam int unsigned CNT_BITS  = 3;
    localparam int unsigned NUM_CAND  = 8;

    typedef logic [CNT_BITS-1:0] cnt_t;

endpackage

`default_nettype wire

// ----- hdl/rect_partial_outline_points_core.sv -----
// An accepted input word passes through the input register, the set-up register, the
// 33 remainder stages, stages A to C and the output serialiser before m_valid rises.
// Throughput: one input word per cycle into the pipeline while it is not stalled; the
// result side sends one word per cycle while m_ready is high, and an item with n points
// (1 to 6) is sent as n words. The rate is set by the single result port; the 33-stage
// remainder pipeline only adds latency. Reset (aresetn, synchronous, active low) clears all valid bits.
`default_nettype none

module rect_partial_outline_points_core #(
    parameter int COORD_BITS = 24
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire  signed [COORD_BITS-1:0]     s_rect_x,
    input  wire  signed [COORD_BITS-1:0]     s_rect_y,
    input  wire  signed [COORD_BITS-1:0]     s_rect_w,
    input  wire  signed [COORD_BITS-1:0]     s_rect_h,
    input  wire  signed [rpop_pkg::DIST_BITS-1:0] s_start_distance,
    input  wire  signed [rpop_pkg::DIST_BITS-1:0] s_span_length,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic signed [COORD_BITS:0]       m_point_x,
    output logic signed [COORD_BITS:0]       m_point_y,
    output logic                             m_is_empty,
    output logic                             m_last
);

    localparam int CB = COORD_BITS;
    localparam int OB = CB + 1;
    localparam int PB = CB + 1;
    localparam int TB = PB + 1;
    localparam int DB = rpop_pkg::DIV_BITS;
    localparam int NP = rpop_pkg::MAX_PTS;
    localparam int NC = rpop_pkg::NUM_CAND;

    typedef struct packed {
        logic [CB-1:0] ox;
        logic [CB-1:0] oy;
    } off_t;

    function automatic off_t point_off(input logic [PB-1:0] pos, input logic [PB-1:0] wu,
                                       input logic [PB-1:0] hu, input logic [PB-1:0] per);
        logic [PB-1:0] wh;
        logic [PB-1:0] w2h;
        off_t o;
        wh  = wu + hu;
        w2h = wh + wu;
        if (pos <= wu) begin
            o.ox = pos[CB-1:0];
            o.oy = '0;
        end else if (pos <= wh) begin
            o.ox = wu[CB-1:0];
            o.oy = CB'(pos - wu);
        end else if (pos <= w2h) begin
            o.ox = CB'(w2h - pos);
            o.oy = hu[CB-1:0];
        end else begin
            o.ox = '0;
            o.oy = CB'(per - pos);
        end
        return o;
    endfunction

    logic en;
    logic ser_take;

    // input stage
    logic                  v0_reg;
    logic signed [CB-1:0]  x0_reg, y0_reg, w0_reg, h0_reg;
    logic signed [rpop_pkg::DIST_BITS-1:0] d0_reg, l0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x0_reg <= s_rect_x;
            y0_reg <= s_rect_y;
            w0_reg <= s_rect_w;
            h0_reg <= s_rect_h;
            d0_reg <= s_start_distance;
            l0_reg <= s_span_length;
        end
    end

    assign s_ready = en;

    // set-up for remainder
    logic [PB-1:0]        whs_next, per_next, lenc_next;
    logic signed [DB-1:0] dsum_next;
    logic [DB-1:0]        mag_next, alen_next;
    logic                 neg_next, empty_next;

    always_comb begin
        empty_next = (w0_reg <= 0) || (h0_reg <= 0);
        whs_next   = PB'(w0_reg) + PB'(h0_reg);
        per_next   = {whs_next[PB-2:0], 1'b0};
        dsum_next  = DB'(d0_reg) + ((l0_reg < 0) ? DB'(l0_reg) : DB'(0));
        neg_next   = dsum_next[DB-1];
        mag_next   = neg_next ? (~dsum_next + DB'(1)) : dsum_next;
        alen_next  = (l0_reg < 0) ? (~DB'(l0_reg) + DB'(1)) : DB'(l0_reg);
        lenc_next  = (alen_next > DB'(per_next)) ? per_next : alen_next[PB-1:0];
    end

    logic                 dv_reg    [0:DB];
    logic [PB-1:0]        drem_reg  [0:DB];
    logic [DB-1:0]        dmag_reg  [0:DB];
    logic [PB-1:0]        dper_reg  [0:DB];
    logic [PB-1:0]        dlen_reg  [0:DB];
    logic                 dneg_reg  [0:DB];
    logic                 demp_reg  [0:DB];
    logic signed [CB-1:0] dx_reg    [0:DB];
    logic signed [CB-1:0] dy_reg    [0:DB];
    logic signed [CB-1:0] dw_reg    [0:DB];
    logic signed [CB-1:0] dh_reg    [0:DB];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg[0] <= 1'b0;
        end else if (en) begin
            dv_reg[0] <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            drem_reg[0] <= '0;
            dmag_reg[0] <= mag_next;
            dper_reg[0] <= per_next;
            dlen_reg[0] <= lenc_next;
            dneg_reg[0] <= neg_next;
            demp_reg[0] <= empty_next;
            dx_reg[0]   <= x0_reg;
            dy_reg[0]   <= y0_reg;
            dw_reg[0]   <= w0_reg;
            dh_reg[0]   <= h0_reg;
        end
    end

    for (genvar j = 1; j <= DB; j++) begin : g_div
        logic [PB:0]   trial;
        logic [PB-1:0] rem_next;

        always_comb begin
            trial = {drem_reg[j-1], dmag_reg[j-1][DB-1]};
            if (trial >= {1'b0, dper_reg[j-1]}) begin
                rem_next = PB'(trial - {1'b0, dper_reg[j-1]});
            end else begin
                rem_next = trial[PB-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[j] <= 1'b0;
            end else if (en) begin
                dv_reg[j] <= dv_reg[j-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                drem_reg[j] <= rem_next;
                dmag_reg[j] <= {dmag_reg[j-1][DB-2:0], 1'b0};
                dper_reg[j] <= dper_reg[j-1];
                dlen_reg[j] <= dlen_reg[j-1];
                dneg_reg[j] <= dneg_reg[j-1];
                demp_reg[j] <= demp_reg[j-1];
                dx_reg[j]   <= dx_reg[j-1];
                dy_reg[j]   <= dy_reg[j-1];
                dw_reg[j]   <= dw_reg[j-1];
                dh_reg[j]   <= dh_reg[j-1];
            end
        end
    end

    // stage A: wrap start and end distances
    logic [PB-1:0] ad_next, adp_next, atw_next;
    logic [TB-1:0] atgt_next, per2;

    always_comb begin
        ad_next   = dneg_reg[DB] ? (dper_reg[DB] - drem_reg[DB]) : drem_reg[DB];
        atgt_next = TB'(ad_next) + TB'(dlen_reg[DB]);
        adp_next  = (ad_next == dper_reg[DB]) ? '0 : ad_next;
        per2      = {dper_reg[DB], 1'b0};
        if (atgt_next >= per2) begin
            atw_next = PB'(atgt_next - per2);
        end else if (atgt_next >= TB'(dper_reg[DB])) begin
            atw_next = PB'(atgt_next - TB'(dper_reg[DB]));
        end else begin
            atw_next = atgt_next[PB-1:0];
        end
    end

    logic                 av_reg;
    logic [PB-1:0]        ad_reg, adp_reg, atw_reg, aper_reg;
    logic [TB-1:0]        atgt_reg;
    logic                 alz_reg, aemp_reg;
    logic signed [CB-1:0] ax_reg, ay_reg, aw_reg, ah_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            av_reg <= 1'b0;
        end else if (en) begin
            av_reg <= dv_reg[DB];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ad_reg   <= ad_next;
            adp_reg  <= adp_next;
            atw_reg  <= atw_next;
            atgt_reg <= atgt_next;
            aper_reg <= dper_reg[DB];
            alz_reg  <= (dlen_reg[DB] == '0);
            aemp_reg <= demp_reg[DB];
            ax_reg   <= dx_reg[DB];
            ay_reg   <= dy_reg[DB];
            aw_reg   <= dw_reg[DB];
            ah_reg   <= dh_reg[DB];
        end
    end

    // stage B: end points and corner flags
    logic [PB-1:0] wu, hu;
    off_t          so, eo;
    logic [TB-1:0] cand [0:NC-1];
    logic [NC-1:0] flag_next;

    always_comb begin
        wu = PB'(aw_reg);
        hu = PB'(ah_reg);
        so = point_off(adp_reg, wu, hu, aper_reg);
        eo = point_off(atw_reg, wu, hu, aper_reg);
        cand[0] = TB'(wu);
        cand[1] = TB'(wu) + TB'(hu);
        cand[2] = cand[1] + TB'(wu);
        cand[3] = TB'(aper_reg);
        cand[4] = cand[3] + cand[0];
        cand[5] = cand[3] + cand[1];
        cand[6] = cand[3] + cand[2];
        cand[7] = {aper_reg, 1'b0};
        for (int k = 0; k < NC; k++) begin
            flag_next[k] = (TB'(ad_reg) < cand[k]) && (cand[k] < atgt_reg);
        end
    end

    logic                 bv_reg;
    logic [OB-1:0]        bsx_reg, bsy_reg, bex_reg, bey_reg;
    logic [OB-1:0]        bx_reg, by_reg, bxw_reg, byh_reg;
    logic [NC-1:0]        bflag_reg;
    logic                 blz_reg, bemp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bv_reg <= 1'b0;
        end else if (en) begin
            bv_reg <= av_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bsx_reg   <= OB'(ax_reg) + OB'(so.ox);
            bsy_reg   <= OB'(ay_reg) + OB'(so.oy);
            bex_reg   <= OB'(ax_reg) + OB'(eo.ox);
            bey_reg   <= OB'(ay_reg) + OB'(eo.oy);
            bx_reg    <= OB'(ax_reg);
            by_reg    <= OB'(ay_reg);
            bxw_reg   <= OB'(ax_reg) + OB'(aw_reg);
            byh_reg   <= OB'(ay_reg) + OB'(ah_reg);
            bflag_reg <= flag_next;
            blz_reg   <= alz_reg;
            bemp_reg  <= aemp_reg;
        end
    end

    // stage C: pack the point list
    logic [OB-1:0]  px_next [0:NP-1];
    logic [OB-1:0]  py_next [0:NP-1];
    rpop_pkg::cnt_t n_next;

    always_comb begin
        for (int k = 0; k < NP; k++) begin
            px_next[k] = '0;
            py_next[k] = '0;
        end
        n_next = rpop_pkg::cnt_t'(1);
        if (!bemp_reg) begin
            px_next[0] = bsx_reg;
            py_next[0] = bsy_reg;
            for (int k = 0; k < NC; k++) begin
                if (bflag_reg[k] && (n_next < rpop_pkg::cnt_t'(NP))) begin
                    px_next[n_next] = ((k % 4) == 0 || (k % 4) == 1) ? bxw_reg : bx_reg;
                    py_next[n_next] = ((k % 4) == 1 || (k % 4) == 2) ? byh_reg : by_reg;
                    n_next = n_next + rpop_pkg::cnt_t'(1);
                end
            end
            if (!blz_reg && (n_next < rpop_pkg::cnt_t'(NP))) begin
                px_next[n_next] = bex_reg;
                py_next[n_next] = bey_reg;
                n_next = n_next + rpop_pkg::cnt_t'(1);
            end
        end
    end

    logic           cv_reg, cemp_reg;
    logic [OB-1:0]  cx_reg [0:NP-1];
    logic [OB-1:0]  cy_reg [0:NP-1];
    rpop_pkg::cnt_t cn_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cv_reg <= 1'b0;
        end else if (en) begin
            cv_reg <= bv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cx_reg   <= px_next;
            cy_reg   <= py_next;
            cn_reg   <= n_next;
            cemp_reg <= bemp_reg;
        end
    end

    // output serialiser: shift one word out per transfer
    logic           ser_v_reg, ser_emp_reg;
    logic [OB-1:0]  ser_x_reg [0:NP-1];
    logic [OB-1:0]  ser_y_reg [0:NP-1];
    rpop_pkg::cnt_t ser_cnt_reg;

    assign ser_take = !ser_v_reg || (m_ready && (ser_cnt_reg == rpop_pkg::cnt_t'(1)));
    assign en       = !cv_reg || ser_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ser_v_reg   <= 1'b0;
            ser_cnt_reg <= '0;
        end else if (ser_take) begin
            ser_v_reg   <= cv_reg;
            ser_cnt_reg <= cv_reg ? cn_reg : '0;
        end else if (m_ready) begin
            ser_cnt_reg <= ser_cnt_reg - rpop_pkg::cnt_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (ser_take) begin
            ser_x_reg   <= cx_reg;
            ser_y_reg   <= cy_reg;
            ser_emp_reg <= cemp_reg;
        end else if (m_ready) begin
            for (int k = 0; k < NP - 1; k++) begin
                ser_x_reg[k] <= ser_x_reg[k+1];
                ser_y_reg[k] <= ser_y_reg[k+1];
            end
        end
    end

    assign m_valid    = ser_v_reg;
    assign m_point_x  = ser_x_reg[0];
    assign m_point_y  = ser_y_reg[0];
    assign m_is_empty = ser_emp_reg;
    assign m_last     = (ser_cnt_reg == rpop_pkg::cnt_t'(1));

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (ser_cnt_reg != '0) && (ser_cnt_reg <= rpop_pkg::cnt_t'(NP)))
        else $error("result count out of range");

    a_empty_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_empty) |-> m_last)
        else $error("empty result not alone");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (cv_reg && !en) |=> cv_reg)
        else $error("stalled word lost");

    a_cnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=>
            (m_valid && (ser_cnt_reg == $past(ser_cnt_reg) - rpop_pkg::cnt_t'(1))))
        else $error("result sequence broken");

endmodule

`default_nettype wire

// ----- sim/rect_partial_outline_points_core_test.sv -----
`timescale 1ns / 100ps
`default_nettype none

module rect_partial_outline_points_core_test;

    localparam int CB = 24;
    localparam int DB = rpop_pkg::DIST_BITS;
    localparam int N_RANDOM = 200;
    localparam int N_DIR = 20;
    localparam int LIMIT = 300000;

    typedef struct {
        logic signed [CB:0] px;
        logic signed [CB:0] py;
        logic               empty;
        logic               last;
    } point_t;

    typedef struct {
        logic signed [CB-1:0] x, y, w, h;
        logic signed [DB-1:0] d, len;
        bit                   typed;
    } stim_t;

    logic                 aclk = 0;
    logic                 aresetn = 0;
    logic                 s_valid = 0;
    wire                  s_ready;
    logic signed [CB-1:0] s_rect_x = 0, s_rect_y = 0, s_rect_w = 0, s_rect_h = 0;
    logic signed [DB-1:0] s_start_distance = 0, s_span_length = 0;
    wire                  m_valid;
    logic                 m_ready = 0;
    wire signed [CB:0]    m_point_x, m_point_y;
    wire                  m_is_empty, m_last;

    point_t outline_q[$];
    int     errors = 0;
    int     sent_words = 0;
    int     cycles = 0;
    bit     hold_off = 0;
    stim_t  dir_tab[N_DIR];

    rect_partial_outline_points_core #(.COORD_BITS(CB)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_rect_x(s_rect_x), .s_rect_y(s_rect_y), .s_rect_w(s_rect_w), .s_rect_h(s_rect_h),
        .s_start_distance(s_start_distance), .s_span_length(s_span_length),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_point_x(m_point_x), .m_point_y(m_point_y),
        .m_is_empty(m_is_empty), .m_last(m_last)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
    end

    function automatic void expect_point(point_t p);
        outline_q.insert(outline_q.size(), p);
    endfunction

    function automatic longint wrap_dist(longint v, longint per);
        if (v < 0) return per + (v % per);
        if (v >= per) return v % per;
        return v;
    endfunction

    function automatic void locate(longint x, longint y, longint w, longint h, longint v,
                                   output longint px, output longint py);
        v = wrap_dist(v, 2 * (w + h));
        if (v <= w) begin
            px = x + v; py = y;
        end else if (v <= w + h) begin
            px = x + w; py = y + v - w;
        end else if (v <= 2 * w + h) begin
            px = x + w - (v - w - h); py = y + h;
        end else begin
            px = x; py = y + h - (v - 2 * w - h);
        end
    endfunction

    function automatic void trace_outline(stim_t s);
        longint x, y, w, h, d, len, per, target, px, py, c, base;
        longint xs[6], ys[6];
        longint corner[4];
        int     n, idx;
        point_t p;
        x = s.x; y = s.y; w = s.w; h = s.h; d = s.d; len = s.len;
        n = 0;
        if (w <= 0 || h <= 0) begin
            p.px = '0; p.py = '0; p.empty = 1'b1; p.last = 1'b1;
            expect_point(p);
            return;
        end
        per = 2 * (w + h);
        if (len < 0) begin
            d = d + len;
            len = -len;
        end
        d = wrap_dist(d, per);
        if (len > per) len = per;
        locate(x, y, w, h, d, px, py);
        xs[0] = px; ys[0] = py; n = 1;
        if (len != 0) begin
            target = d + len;
            corner[0] = w; corner[1] = w + h; corner[2] = 2 * w + h; corner[3] = per;
            for (int ps = 0; ps < 3; ps++) begin
                base = ps * per;
                if (base <= target) begin
                    for (int i = 0; i < 4; i++) begin
                        c = base + corner[i];
                        if (d < c && c < target) begin
                            idx = (i + 1) & 3;
                            px = (idx == 1 || idx == 2) ? x + w : x;
                            py = (idx >= 2) ? y + h : y;
                            if (!(xs[n-1] == px && ys[n-1] == py) && n < 6) begin
                                xs[n] = px; ys[n] = py; n++;
                            end
                        end
                    end
                end
            end
            locate(x, y, w, h, target, px, py);
            if (!(xs[n-1] == px && ys[n-1] == py) && n < 6) begin
                xs[n] = px; ys[n] = py; n++;
            end
        end
        for (int k = 0; k < n; k++) begin
            p.px = (CB+1)'(xs[k]); p.py = (CB+1)'(ys[k]);
            p.empty = 1'b0; p.last = (k == n - 1);
            expect_point(p);
        end
    endfunction

    task automatic report(string what, logic [CB:0] got, logic [CB:0] want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    always @(posedge aclk) begin
        point_t e;
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            if (outline_q.size() == 0) begin
                report("unexpected word", m_point_x, '0);
            end else begin
                e = outline_q.pop_front();
                if (m_point_x !== e.px) report("point_x", m_point_x, e.px);
                if (m_point_y !== e.py) report("point_y", m_point_y, e.py);
                if (m_is_empty !== e.empty) begin
                    report("is_empty", (CB+1)'(m_is_empty), (CB+1)'(e.empty));
                end
                if (m_last !== e.last) begin
                    report("last", (CB+1)'(m_last), (CB+1)'(e.last));
                end
            end
        end
    end

    initial begin
        logic [15:0] pat;
        int          mode;
        forever begin
            mode = int'($urandom_range(0, 3));
            pat = 16'($urandom);
            for (int i = 0; i < 16; i++) begin
                @(negedge aclk);
                m_ready <= !hold_off && (mode == 0 || pat[i]);
            end
        end
    end

    initial begin
        wait (sent_words >= 140);
        hold_off = 1;
        repeat (400) @(posedge aclk);
        hold_off = 0;
    end

    initial begin
        wait (cycles >= LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    task automatic send_word(stim_t s);
        point_t p;
        @(negedge aclk);
        s_rect_x <= s.x; s_rect_y <= s.y; s_rect_w <= s.w; s_rect_h <= s.h;
        s_start_distance <= s.d; s_span_length <= s.len;
        s_valid <= 1;
        do @(posedge aclk); while (!(s_valid && s_ready));
        if (s.typed) begin
            p.px = '0; p.py = '0; p.empty = 1'b1; p.last = 1'b1;
            expect_point(p);
        end else begin
            trace_outline(s);
        end
        sent_words++;
    endtask

    function automatic stim_t mk(int x, int y, int w, int h, int d, int len, bit typed = 0);
        stim_t s;
        s.x = CB'(x); s.y = CB'(y); s.w = CB'(w); s.h = CB'(h);
        s.d = d; s.len = len; s.typed = typed;
        return s;
    endfunction

    function automatic stim_t pick_random();
        stim_t s;
        int    per;
        s.typed = 0;
        s.x = CB'($urandom); s.y = CB'($urandom);
        if ($urandom_range(0, 9) == 0) begin
            s.w = CB'($urandom); s.h = CB'($urandom);
        end else begin
            s.w = CB'($urandom_range(1, 4000)); s.h = CB'($urandom_range(1, 4000));
        end
        if ($urandom_range(0, 7) == 0 || s.w <= 0 || s.h <= 0) begin
            s.d = $urandom; s.len = $urandom;
        end else begin
            per = 2 * (s.w + s.h);
            s.d = $urandom_range(0, 6 * per) - 3 * per;
            case ($urandom_range(0, 3))
                0: s.len = 0;
                1: s.len = per * ($urandom_range(0, 1) ? 1 : -1);
                default: s.len = $urandom_range(0, 4 * per) - 2 * per;
            endcase
            if ($urandom_range(0, 5) == 0) s.d = ($urandom_range(0, 3) - 1) * per;
        end
        return s;
    endfunction

    initial begin
        int burst, wait_cnt;
        dir_tab = '{
            mk(0, 0, 0, 100, 5, 5, 1),
            mk(10, 10, 100, -1, 5, 5, 1),
            mk(-8388608, 8388607, -8388608, -8388608, -1, 1, 1),
            mk(8388607, 8388607, 8388607, 8388607, 0, 32'h7fffffff),
            mk(-8388608, -8388608, 8388607, 8388607, 32'h80000000, 32'h80000000),
            mk(100, 200, 256, 512, 300, 0),
            mk(100, 200, 256, 512, 300, -200),
            mk(0, 0, 256, 512, -1536, 100),
            mk(0, 0, 256, 512, -3072, 100),
            mk(0, 0, 256, 512, 1536, 100),
            mk(0, 0, 256, 512, 5000, 100),
            mk(0, 0, 256, 512, 0, 1536),
            mk(0, 0, 256, 512, 10, 9000),
            mk(0, 0, 256, 512, 256, 512),
            mk(0, 0, 256, 512, 768, 1),
            mk(0, 0, 256, 512, 1024, -1024),
            mk(-50, -60, 1, 1, 0, 4),
            mk(7, 9, 1, 1, 3, -5),
            mk(0, 0, 256, 512, 100, 1535),
            mk(0, 0, 256, 512, -1, -32'h7fffffff)
        };

        wait (aresetn);
        foreach (dir_tab[i]) send_word(dir_tab[i]);
        @(negedge aclk);
        s_valid <= 0;
        wait (outline_q.size() == 0);

        burst = 0;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 20);
                wait_cnt = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12);
                if (wait_cnt > 0) begin
                    @(negedge aclk);
                    s_valid <= 0;
                    repeat (wait_cnt - 1) @(negedge aclk);
                end
            end
            if (i == 100) begin
                @(negedge aclk);
                s_valid <= 0;
                wait (outline_q.size() == 0);
            end
            send_word(pick_random());
            burst--;
        end
        @(negedge aclk);
        s_valid <= 0;

        wait (outline_q.size() == 0);
        repeat (60) @(posedge aclk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

`default_nettype wire
